// ===== rtl/sd_spi_host_sequencer_defines.svh =====
// Assertion macros for the SD SPI host sequencer
`ifndef SD_SPI_HOST_SEQUENCER_DEFINES_SVH
`define SD_SPI_HOST_SEQUENCER_DEFINES_SVH
`ifndef SYNTHESIS
`define SSHS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SSHS_ASSERT_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SSHS_ASSERT(label, clk, rst_n, prop, msg)
`define SSHS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== rtl/sdspi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdspi_pkg
// Shared constants and types of the SD SPI host sequencer.
// ----------------------------------------------------------------------------
package sdspi_pkg;
	localparam int RESET_ATTEMPTS = 11;
	localparam int READY_ATTEMPTS = 5;
	localparam int FLUSH_BYTES    = 10;

	localparam logic [1:0] OP_BYTE  = 2'd0;
	localparam logic [1:0] OP_INIT  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_TICK  = 2'd3;

	localparam logic [1:0] CFG_BLOCK_SIZE = 2'd0;
	localparam logic [1:0] CFG_TOKEN_POLL = 2'd1;
	localparam logic [1:0] CFG_RESP_POLL  = 2'd2;
	localparam logic [1:0] CFG_RETRY_DLY  = 2'd3;

	localparam logic [3:0] PH_IDLE  = 4'd0;
	localparam logic [3:0] PH_FLUSH = 4'd1;
	localparam logic [3:0] PH_PRE   = 4'd2;
	localparam logic [3:0] PH_SEL   = 4'd3;
	localparam logic [3:0] PH_CMD   = 4'd4;
	localparam logic [3:0] PH_ARG   = 4'd5;
	localparam logic [3:0] PH_CRC   = 4'd6;
	localparam logic [3:0] PH_STUFF = 4'd7;
	localparam logic [3:0] PH_POLL  = 4'd8;
	localparam logic [3:0] PH_TRAIL = 4'd9;
	localparam logic [3:0] PH_DELAY = 4'd10;
	localparam logic [3:0] PH_TOKEN = 4'd11;
	localparam logic [3:0] PH_DATA  = 4'd12;
	localparam logic [3:0] PH_DCRC  = 4'd13;

	localparam logic [2:0] NX_CMD0   = 3'd0;
	localparam logic [2:0] NX_CMD8   = 3'd1;
	localparam logic [2:0] NX_CMD58  = 3'd2;
	localparam logic [2:0] NX_READY  = 3'd3;
	localparam logic [2:0] NX_FINISH = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_RESP = 2'd1;
	localparam logic [1:0] ST_ERROR   = 2'd2;

	typedef struct packed {
		logic [12:0] block_size;
		logic [15:0] token_poll_limit;
		logic [7:0]  response_poll_limit;
		logic [15:0] retry_delay_ticks;
	} cfg_t;

	typedef struct packed {
		logic [3:0]  phase;
		logic [15:0] byte_count;
		logic [3:0]  attempt_count;
		logic [15:0] delay_count;
		logic [5:0]  command_code;
		logic [31:0] command_argument;
		logic [7:0]  command_crc;
		logic [7:0]  last_r1;
		logic        card_v2;
		logic        select_level;
		logic        fast_mode;
		logic [2:0]  flush_next;
		logic [1:0]  pending_status;
	} state_t;

	typedef struct packed {
		logic [7:0] send_byte;
		logic       send_valid;
		logic       chip_select_n;
		logic       fast_clock;
		logic [7:0] data_byte;
		logic       data_valid;
		logic       data_last;
		logic       done_res;
		logic [1:0] status;
		logic       card_v2;
		logic [7:0] r1_response;
	} result_t;
endpackage

// ===== rtl/sdspi_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdspi_cfg_regs
// Configuration register file of the SD SPI host sequencer.
// ----------------------------------------------------------------------------
module sdspi_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output sdspi_pkg::cfg_t    cfg
);
	sdspi_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.block_size          <= 13'd512;
			cfg_q.token_poll_limit    <= 16'd15063;
			cfg_q.response_poll_limit <= 8'd48;
			cfg_q.retry_delay_ticks   <= 16'd10;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sdspi_pkg::CFG_BLOCK_SIZE: cfg_q.block_size <= cfg_data[12:0];
				sdspi_pkg::CFG_TOKEN_POLL: cfg_q.token_poll_limit <= cfg_data;
				sdspi_pkg::CFG_RESP_POLL:  cfg_q.response_poll_limit <= cfg_data[7:0];
				sdspi_pkg::CFG_RETRY_DLY:  cfg_q.retry_delay_ticks <= cfg_data;
				default: ;
			endcase
		end
	end
endmodule

// ===== rtl/sdspi_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdspi_step
// Next-state and result logic for one sequencer step.
// ----------------------------------------------------------------------------
module sdspi_step #(
	parameter int RESET_ATTEMPTS = sdspi_pkg::RESET_ATTEMPTS,
	parameter int READY_ATTEMPTS = sdspi_pkg::READY_ATTEMPTS,
	parameter int FLUSH_BYTES    = sdspi_pkg::FLUSH_BYTES
) (
	input  sdspi_pkg::cfg_t    cfg,
	input  sdspi_pkg::state_t  cur,
	input  logic [1:0]         opcode,
	input  logic [7:0]         miso_byte,
	input  logic [31:0]        block_address,
	output sdspi_pkg::state_t  nxt,
	output sdspi_pkg::result_t res
);
	localparam logic [3:0]  RESET_ATT = 4'(RESET_ATTEMPTS);
	localparam logic [3:0]  READY_ATT = 4'(READY_ATTEMPTS);
	localparam logic [15:0] FLUSH_N   = 16'(FLUSH_BYTES);
	localparam logic [15:0] FLUSH_2N  = 16'(2 * FLUSH_BYTES);

	sdspi_pkg::state_t s;
	logic        handled;
	logic        done;
	logic [1:0]  st;
	logic        dvalid;
	logic        dlast;
	logic [7:0]  dbyte;
	logic        after_cmd;
	logic [7:0]  r1_in;
	logic        after_dly;
	logic [15:0] bc_inc;
	logic [15:0] dc_inc;
	logic        pend;
	logic [1:0]  arg_sel;

	always_comb begin
		s         = cur;
		handled   = 1'b0;
		done      = 1'b0;
		st        = sdspi_pkg::ST_OK;
		dvalid    = 1'b0;
		dlast     = 1'b0;
		dbyte     = 8'd0;
		after_cmd = 1'b0;
		r1_in     = 8'hFF;
		after_dly = 1'b0;
		bc_inc    = cur.byte_count + 16'd1;
		dc_inc    = cur.delay_count + 16'd1;

		unique case (opcode)
			sdspi_pkg::OP_INIT: begin
				if (cur.phase == sdspi_pkg::PH_IDLE) begin
					handled          = 1'b1;
					s.fast_mode      = 1'b0;
					s.select_level   = 1'b1;
					s.phase          = sdspi_pkg::PH_FLUSH;
					s.byte_count     = '0;
					s.flush_next     = sdspi_pkg::NX_CMD0;
					s.pending_status = sdspi_pkg::ST_OK;
				end
			end
			sdspi_pkg::OP_READ: begin
				if (cur.phase == sdspi_pkg::PH_IDLE) begin
					handled            = 1'b1;
					s.command_code     = 6'd17;
					s.command_argument = block_address;
					s.command_crc      = 8'h00;
					s.phase            = sdspi_pkg::PH_PRE;
					s.byte_count       = '0;
				end
			end
			sdspi_pkg::OP_TICK: begin
				if (cur.phase == sdspi_pkg::PH_DELAY) begin
					handled       = 1'b1;
					s.delay_count = dc_inc;
					if (dc_inc >= cfg.retry_delay_ticks) after_dly = 1'b1;
				end
			end
			default: begin
				if (cur.phase != sdspi_pkg::PH_IDLE && cur.phase != sdspi_pkg::PH_DELAY) begin
					handled = 1'b1;
					unique case (cur.phase)
						sdspi_pkg::PH_FLUSH: begin
							s.byte_count = bc_inc;
							if (bc_inc >= ((cur.flush_next == sdspi_pkg::NX_CMD8) ?
									FLUSH_2N : FLUSH_N)) begin
								unique case (cur.flush_next)
									sdspi_pkg::NX_CMD0: begin
										s.attempt_count = '0;
										s.command_code = 6'd0;
										s.command_argument = '0;
										s.command_crc = 8'h94;
										s.phase = sdspi_pkg::PH_PRE;
										s.byte_count = '0;
									end
									sdspi_pkg::NX_CMD8: begin
										s.command_code = 6'd8;
										s.command_argument = 32'h1AA;
										s.command_crc = 8'h86;
										s.phase = sdspi_pkg::PH_PRE;
										s.byte_count = '0;
									end
									sdspi_pkg::NX_CMD58: begin
										s.command_code = 6'd58;
										s.command_argument = '0;
										s.command_crc = 8'h00;
										s.phase = sdspi_pkg::PH_PRE;
										s.byte_count = '0;
									end
									sdspi_pkg::NX_READY: begin
										if (cur.last_r1 == 8'h00) begin
											s.fast_mode = 1'b1;
											s.phase = sdspi_pkg::PH_IDLE;
											done = 1'b1;
											st = sdspi_pkg::ST_OK;
										end else begin
											s.attempt_count = cur.attempt_count + 4'd1;
											if (cfg.retry_delay_ticks == 16'd0) begin
												after_dly = 1'b1;
											end else begin
												s.phase = sdspi_pkg::PH_DELAY;
												s.delay_count = '0;
											end
										end
									end
									default: begin
										s.phase = sdspi_pkg::PH_IDLE;
										done = 1'b1;
										st = cur.pending_status;
									end
								endcase
							end
						end
						sdspi_pkg::PH_PRE: begin
							s.select_level = 1'b0;
							s.phase = sdspi_pkg::PH_SEL;
							s.byte_count = '0;
						end
						sdspi_pkg::PH_SEL: begin
							s.byte_count = bc_inc;
							if (bc_inc >= 16'd4) s.phase = sdspi_pkg::PH_CMD;
						end
						sdspi_pkg::PH_CMD: begin
							s.phase = sdspi_pkg::PH_ARG;
							s.byte_count = '0;
						end
						sdspi_pkg::PH_ARG: begin
							s.byte_count = bc_inc;
							if (bc_inc >= 16'd4) s.phase = sdspi_pkg::PH_CRC;
						end
						sdspi_pkg::PH_CRC, sdspi_pkg::PH_STUFF: begin
							if (cur.phase == sdspi_pkg::PH_CRC && cur.command_code == 6'd12) begin
								s.phase = sdspi_pkg::PH_STUFF;
							end else begin
								s.byte_count = '0;
								if (cfg.response_poll_limit == 8'd0) after_cmd = 1'b1;
								else s.phase = sdspi_pkg::PH_POLL;
							end
						end
						sdspi_pkg::PH_POLL: begin
							if (miso_byte != 8'hFF) begin
								after_cmd = 1'b1;
								r1_in = miso_byte;
							end else begin
								s.byte_count = bc_inc;
								if (bc_inc >= {8'd0, cfg.response_poll_limit}) after_cmd = 1'b1;
							end
						end
						sdspi_pkg::PH_TRAIL: begin
							s.byte_count = bc_inc;
							if (bc_inc >= 16'd4) begin
								if (cur.command_code == 6'd8) begin
									s.select_level = 1'b1;
									s.phase = sdspi_pkg::PH_FLUSH;
									s.byte_count = '0;
									s.flush_next = sdspi_pkg::NX_CMD58;
									s.pending_status = sdspi_pkg::ST_OK;
								end else begin
									s.attempt_count = '0;
									s.command_code = 6'd55;
									s.command_argument = '0;
									s.command_crc = 8'h65;
									s.phase = sdspi_pkg::PH_PRE;
									s.byte_count = '0;
								end
							end
						end
						sdspi_pkg::PH_TOKEN: begin
							if (miso_byte != 8'hFF) begin
								if (miso_byte == 8'hFE) begin
									s.byte_count = '0;
									s.phase = (cfg.block_size == 13'd0) ?
										sdspi_pkg::PH_DCRC : sdspi_pkg::PH_DATA;
								end else begin
									s.select_level = 1'b1;
									s.phase = sdspi_pkg::PH_FLUSH;
									s.byte_count = '0;
									s.flush_next = sdspi_pkg::NX_FINISH;
									s.pending_status = sdspi_pkg::ST_NO_RESP;
								end
							end else begin
								s.byte_count = bc_inc;
								if (bc_inc >= cfg.token_poll_limit) begin
									s.select_level = 1'b1;
									s.phase = sdspi_pkg::PH_FLUSH;
									s.byte_count = '0;
									s.flush_next = sdspi_pkg::NX_FINISH;
									s.pending_status = sdspi_pkg::ST_NO_RESP;
								end
							end
						end
						sdspi_pkg::PH_DATA: begin
							dvalid = 1'b1;
							dbyte = miso_byte;
							s.byte_count = bc_inc;
							if (bc_inc >= {3'd0, cfg.block_size}) begin
								dlast = 1'b1;
								s.phase = sdspi_pkg::PH_DCRC;
								s.byte_count = '0;
							end
						end
						sdspi_pkg::PH_DCRC: begin
							s.byte_count = bc_inc;
							if (bc_inc >= 16'd2) begin
								s.select_level = 1'b1;
								s.phase = sdspi_pkg::PH_FLUSH;
								s.byte_count = '0;
								s.flush_next = sdspi_pkg::NX_FINISH;
								s.pending_status = sdspi_pkg::ST_OK;
							end
						end
						default: ;
					endcase
				end
			end
		endcase

		if (after_cmd) begin
			s.last_r1 = r1_in;
			priority case (cur.command_code)
				6'd0: begin
					if (r1_in == 8'h01) begin
						s.select_level = 1'b1;
						s.phase = sdspi_pkg::PH_FLUSH;
						s.byte_count = '0;
						s.flush_next = sdspi_pkg::NX_CMD8;
						s.pending_status = sdspi_pkg::ST_OK;
					end else begin
						s.attempt_count = cur.attempt_count + 4'd1;
						if (s.attempt_count >= RESET_ATT) begin
							s.select_level = 1'b1;
							s.phase = sdspi_pkg::PH_FLUSH;
							s.byte_count = '0;
							s.flush_next = sdspi_pkg::NX_FINISH;
							s.pending_status = sdspi_pkg::ST_ERROR;
						end else begin
							s.command_code = 6'd0;
							s.command_argument = '0;
							s.command_crc = 8'h94;
							s.phase = sdspi_pkg::PH_PRE;
							s.byte_count = '0;
						end
					end
				end
				6'd8: begin
					if (r1_in == 8'h01) begin
						s.card_v2 = 1'b1;
						s.phase = sdspi_pkg::PH_TRAIL;
						s.byte_count = '0;
					end else begin
						if (r1_in == 8'h04) s.card_v2 = 1'b0;
						s.select_level = 1'b1;
						s.phase = sdspi_pkg::PH_FLUSH;
						s.byte_count = '0;
						s.flush_next = (r1_in == 8'h04) ? sdspi_pkg::NX_CMD58 :
							sdspi_pkg::NX_FINISH;
						s.pending_status = (r1_in == 8'h04) ? sdspi_pkg::ST_OK :
							sdspi_pkg::ST_ERROR;
					end
				end
				6'd58: begin
					s.phase = sdspi_pkg::PH_TRAIL;
					s.byte_count = '0;
				end
				6'd55: begin
					if (r1_in > 8'h01) begin
						s.phase = sdspi_pkg::PH_IDLE;
						done = 1'b1;
						st = sdspi_pkg::ST_ERROR;
					end else begin
						s.command_code = 6'd41;
						s.command_argument = 32'h4000_0000;
						s.command_crc = 8'h00;
						s.phase = sdspi_pkg::PH_PRE;
						s.byte_count = '0;
					end
				end
				6'd41: begin
					s.select_level = 1'b1;
					s.phase = sdspi_pkg::PH_FLUSH;
					s.byte_count = '0;
					s.flush_next = sdspi_pkg::NX_READY;
					s.pending_status = sdspi_pkg::ST_OK;
				end
				6'd17: begin
					s.select_level = (r1_in == 8'hFF) ? 1'b1 : s.select_level;
					s.byte_count = '0;
					if (r1_in == 8'hFF || cfg.token_poll_limit == 16'd0) begin
						s.select_level = 1'b1;
						s.phase = sdspi_pkg::PH_FLUSH;
						s.flush_next = sdspi_pkg::NX_FINISH;
						s.pending_status = (r1_in == 8'hFF) ? sdspi_pkg::ST_ERROR :
							sdspi_pkg::ST_NO_RESP;
					end else begin
						s.phase = sdspi_pkg::PH_TOKEN;
					end
				end
				default: begin
					s.select_level = 1'b1;
					s.phase = sdspi_pkg::PH_FLUSH;
					s.byte_count = '0;
					s.flush_next = sdspi_pkg::NX_FINISH;
					s.pending_status = sdspi_pkg::ST_OK;
				end
			endcase
		end

		if (after_dly) begin
			if (s.attempt_count >= READY_ATT) begin
				s.phase = sdspi_pkg::PH_IDLE;
				done = 1'b1;
				st = sdspi_pkg::ST_ERROR;
			end else begin
				s.command_code = 6'd55;
				s.command_argument = '0;
				s.command_crc = 8'h65;
				s.phase = sdspi_pkg::PH_PRE;
				s.byte_count = '0;
			end
		end

		nxt = s;
		pend = handled && s.phase != sdspi_pkg::PH_IDLE && s.phase != sdspi_pkg::PH_DELAY;
		arg_sel = 2'd3 - s.byte_count[1:0];

		res.send_valid = pend;
		if (!pend) res.send_byte = 8'd0;
		else if (s.phase == sdspi_pkg::PH_CMD) res.send_byte = {2'b01, s.command_code};
		else if (s.phase == sdspi_pkg::PH_ARG)
			res.send_byte = s.command_argument[{arg_sel, 3'b000} +: 8];
		else if (s.phase == sdspi_pkg::PH_CRC) res.send_byte = s.command_crc | 8'h01;
		else res.send_byte = 8'hFF;
		res.chip_select_n = s.select_level;
		res.fast_clock    = s.fast_mode;
		res.data_byte     = dbyte;
		res.data_valid    = dvalid;
		res.data_last     = dlast;
		res.done_res      = done;
		res.status        = st;
		res.card_v2       = s.card_v2;
		res.r1_response   = s.last_r1;
	end
endmodule

// ===== rtl/sd_spi_host_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sd_spi_host_sequencer
// SD card SPI-mode host sequencer: init and single block read, one byte a beat.
// ----------------------------------------------------------------------------
// Every input beat produces exactly one result beat. When a beat is taken,
// the step logic updates the state and loads the result register (or the
// skid stage) in the same edge, so one beat per clock is sustained while the result side
// keeps up; the result register and its skid stage absorb a one-beat stall.
// Configuration writes are accepted at any time and must be made while idle.
`include "sd_spi_host_sequencer_defines.svh"
module sd_spi_host_sequencer #(
	parameter int RESET_ATTEMPTS = sdspi_pkg::RESET_ATTEMPTS,
	parameter int READY_ATTEMPTS = sdspi_pkg::READY_ATTEMPTS,
	parameter int FLUSH_BYTES    = sdspi_pkg::FLUSH_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [7:0]  miso_byte,
	input  logic [31:0] block_address,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  send_byte,
	output logic        send_valid,
	output logic        chip_select_n,
	output logic        fast_clock,
	output logic [7:0]  data_byte,
	output logic        data_valid,
	output logic        data_last,
	output logic        done_res,
	output logic [1:0]  status,
	output logic        card_v2,
	output logic [7:0]  r1_response
);
	sdspi_pkg::cfg_t    cfg;
	sdspi_pkg::state_t  state_q;
	sdspi_pkg::state_t  state_nxt;
	sdspi_pkg::result_t res_nxt;
	sdspi_pkg::result_t out_q;
	sdspi_pkg::result_t skid_q;
	logic               out_valid_q;
	logic               skid_valid_q;
	logic               in_fire;
	logic               out_fire;

	sdspi_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sdspi_step #(
		.RESET_ATTEMPTS (RESET_ATTEMPTS),
		.READY_ATTEMPTS (READY_ATTEMPTS),
		.FLUSH_BYTES    (FLUSH_BYTES)
	) u_step (
		.cfg           (cfg),
		.cur           (state_q),
		.opcode        (opcode),
		.miso_byte     (miso_byte),
		.block_address (block_address),
		.nxt           (state_nxt),
		.res           (res_nxt)
	);

	assign in_ready = !skid_valid_q;
	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase          <= sdspi_pkg::PH_IDLE;
			state_q.byte_count     <= '0;
			state_q.attempt_count  <= '0;
			state_q.delay_count    <= '0;
			state_q.command_code   <= '0;
			state_q.command_argument <= '0;
			state_q.command_crc    <= '0;
			state_q.last_r1        <= 8'hFF;
			state_q.card_v2        <= 1'b0;
			state_q.select_level   <= 1'b1;
			state_q.fast_mode      <= 1'b0;
			state_q.flush_next     <= sdspi_pkg::NX_CMD0;
			state_q.pending_status <= sdspi_pkg::ST_OK;
			out_valid_q            <= 1'b0;
			skid_valid_q           <= 1'b0;
		end else begin
			if (in_fire) state_q <= state_nxt;
			if (out_fire || !out_valid_q) begin
				out_valid_q  <= skid_valid_q || in_fire;
				skid_valid_q <= 1'b0;
			end else if (in_fire) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_fire || !out_valid_q) begin
			out_q <= skid_valid_q ? skid_q : res_nxt;
		end
		if (in_fire && out_valid_q && !out_ready) skid_q <= res_nxt;
	end

	assign out_valid     = out_valid_q;
	assign send_byte     = out_q.send_byte;
	assign send_valid    = out_q.send_valid;
	assign chip_select_n = out_q.chip_select_n;
	assign fast_clock    = out_q.fast_clock;
	assign data_byte     = out_q.data_byte;
	assign data_valid    = out_q.data_valid;
	assign data_last     = out_q.data_last;
	assign done_res      = out_q.done_res;
	assign status        = out_q.status;
	assign card_v2       = out_q.card_v2;
	assign r1_response   = out_q.r1_response;

	`SSHS_ASSERT(a_skid_only_when_stalled, clk, arst_n, skid_valid_q |-> out_valid_q, "skid full without output")
	`SSHS_ASSERT(a_no_accept_when_full, clk, arst_n, skid_valid_q |-> !in_ready, "accepted with skid full")
	`SSHS_ASSERT(a_state_holds_idle_in, clk, arst_n, !in_fire |=> $stable(state_q), "state moved without a beat")
	`SSHS_ASSERT(a_last_with_data, clk, arst_n, (out_valid_q && out_q.data_last) |-> out_q.data_valid, "last without data")
endmodule
